FILE: src/plst_pkg.sv
// ---------------------------------------------------------------------------
// plst_pkg
// Shared constants, codes and types of the positional list store.
// ---------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 38;
    localparam int REQ_W    = 2;
    localparam int ST_W     = 2;

    localparam logic [REQ_W-1:0] REQ_HEAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAIL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POS  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_BOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: src/plst_cell.sv
// ---------------------------------------------------------------------------
// plst_cell
// One entry of the list; shifts toward the tail on insert and toward the
// head on delete, and presents its value when it is the addressed entry.
// ---------------------------------------------------------------------------
module plst_cell (
    input  logic                               i_clk,
    input  plst_pkg::t_cell_ctl                i_ctl,
    input  logic [plst_pkg::IDX_W-1:0]         i_index,
    input  logic [plst_pkg::VAL_W-1:0]         i_left,
    input  logic [plst_pkg::VAL_W-1:0]         i_right,
    output logic [plst_pkg::VAL_W-1:0]         o_value,
    output logic [plst_pkg::VAL_W-1:0]         o_tap
);
    import plst_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic             w_here;
    logic             w_above;

    assign w_here  = (i_index == i_ctl.idx);
    assign w_above = (i_index > i_ctl.idx);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_val = i_left;
            end else if (w_here) begin
                n_val = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (w_above || w_here) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_tap   = r_val & {VAL_W{w_here}};

endmodule

FILE: src/positional_list_store.sv
// ---------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit values with head, tail and
// positional insert and positional delete, reporting count and running sum.
// ---------------------------------------------------------------------------
// When an item is accepted the row of entry cells shifts and the count
// updates; then, once the output register is free, the running sum is
// adjusted and the result is loaded into the output register. A new item
// is accepted only once that result is loaded. Entries need no clearing
// after reset.
module positional_list_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[38:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // element_count[6:0], total[44:7], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import plst_pkg::*;

    logic             r_busy;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [VAL_W-1:0] r_delta;
    logic             r_apply;
    logic             r_sub;
    logic [ST_W-1:0]  r_status;
    logic [ST_W-1:0]  r_out_status;
    logic [6:0]       r_out_count;
    logic [SUM_W-1:0] r_out_sum;

    logic             w_accept;
    logic             w_finish;
    logic [REQ_W-1:0] w_req;
    logic [VAL_W-1:0] w_value;
    logic [POS_W-1:0] w_pos_in;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_idx;
    logic             w_full;
    logic [ST_W-1:0]  w_status;
    logic             w_ins;
    logic             w_del;
    logic [VAL_W-1:0] w_taken;
    t_cell_ctl        w_ctl;

    logic [VAL_W-1:0] w_cell_val [CAPACITY];
    logic [VAL_W-1:0] w_cell_tap [CAPACITY];

    assign w_req    = s_axis_tuser;
    assign w_value  = s_axis_tdata[31:0];
    assign w_pos_in = s_axis_tdata[38:32];
    assign w_pos    = CMP_W'(w_pos_in);
    assign w_cnt    = CMP_W'(r_count);
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_finish      = r_busy && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_status = ST_DONE;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_idx    = '0;
        if (w_req == REQ_DEL) begin
            if (w_pos < w_cnt) begin
                w_del = 1'b1;
                w_idx = w_pos;
            end else begin
                w_status = ST_BOUND;
            end
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            unique case (w_req)
                REQ_HEAD: begin
                    w_ins = 1'b1;
                    w_idx = '0;
                end
                REQ_TAIL: begin
                    w_ins = 1'b1;
                    w_idx = w_cnt;
                end
                default: begin
                    if (r_count == '0) begin
                        w_ins = 1'b1;
                        w_idx = '0;
                    end else if (w_pos <= w_cnt) begin
                        w_ins = 1'b1;
                        w_idx = w_pos;
                    end else begin
                        w_status = ST_BOUND;
                    end
                end
            endcase
        end
    end

    assign w_ctl.ins   = w_accept && w_ins;
    assign w_ctl.del   = w_accept && w_del;
    assign w_ctl.idx   = w_idx[IDX_W-1:0];
    assign w_ctl.value = w_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[i+1];
        end
        plst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(i)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[i]),
            .o_tap   (w_cell_tap[i])
        );
    end

    always_comb begin
        w_taken = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_taken = w_taken | w_cell_tap[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_sum = r_sum;
        if (r_apply) begin
            if (r_sub) begin
                n_sum = r_sum - SUM_W'(signed'(r_delta));
            end else begin
                n_sum = r_sum + SUM_W'(signed'(r_delta));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_apply     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
                r_apply <= w_ins || w_del;
            end else if (w_finish) begin
                r_busy  <= 1'b0;
                r_sum   <= n_sum;
                r_apply <= 1'b0;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_sub    <= w_del;
            r_delta  <= w_del ? w_taken : w_value;
        end
        if (w_finish) begin
            r_out_status <= r_status;
            r_out_count  <= w_cnt[6:0];
            r_out_sum    <= n_sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_sum, r_out_count};

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional list store: a stimulus table of
// head, tail and positional requests on an empty and a short list, then
// random fill and drain runs with random gaps on both streams and long
// output stalls, each result checked against its table row or a behavioral list image.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plst_pkg::*;

    localparam int N_DIRECTED   = 17;
    localparam int N_RANDOM     = 1933;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             typed;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] total;
    } t_list_row;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] total;
    } t_list_reply;

    typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX, FILL_EDGE} t_fill_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [VAL_W-1:0] list_image[$];
    logic [SUM_W-1:0] sum_image = '0;
    t_list_reply      pending_replies[$];

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    int          items_taken = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          growing = 1'b1;
    t_fill_style fill_style = FILL_RANDOM;

    t_list_row directed_rows [0:N_DIRECTED-1] = '{
        '{REQ_DEL,  32'h0000_0000, 7'd0,   1'b1, ST_BOUND, 7'd0, 38'd0},
        '{REQ_POS,  32'h0000_0005, 7'd127, 1'b1, ST_DONE,  7'd1, 38'd5},
        '{REQ_POS,  32'h0000_0007, 7'd3,   1'b1, ST_BOUND, 7'd1, 38'd5},
        '{REQ_POS,  32'h7FFF_FFFF, 7'd1,   1'b1, ST_DONE,  7'd2, 38'd2147483652},
        '{REQ_HEAD, 32'h8000_0000, 7'd0,   1'b1, ST_DONE,  7'd3, 38'd4},
        '{REQ_TAIL, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_DONE,  7'd4, 38'd3},
        '{REQ_DEL,  32'h0000_0000, 7'd4,   1'b1, ST_BOUND, 7'd4, 38'd3},
        '{REQ_DEL,  32'hFFFF_FFFF, 7'd127, 1'b1, ST_BOUND, 7'd4, 38'd3},
        '{REQ_POS,  32'h0000_0000, 7'd2,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_DEL,  32'h0000_0000, 7'd0,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_DEL,  32'h0000_0000, 7'd3,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_POS,  32'h5555_5555, 7'd0,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_TAIL, 32'hAAAA_AAAA, 7'd64,  1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_HEAD, 32'h1234_5678, 7'd100, 1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_DEL,  32'h0000_0000, 7'd2,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_HEAD, 32'h8000_0000, 7'd0,   1'b0, ST_DONE,  7'd0, 38'd0},
        '{REQ_DEL,  32'h0000_0000, 7'd0,   1'b0, ST_DONE,  7'd0, 38'd0}
    };

    positional_list_store DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_list_reply update_list_image(input t_list_row r);
        t_list_reply rep;
        int          n;
        n = list_image.size();
        rep.status = ST_DONE;
        if (r.kind == REQ_DEL) begin
            if (r.pos < n) begin
                sum_image = sum_image - {{(SUM_W-VAL_W){list_image[r.pos][VAL_W-1]}},
                                         list_image[r.pos]};
                list_image.delete(int'(r.pos));
            end else begin
                rep.status = ST_BOUND;
            end
        end else if (n >= CAPACITY) begin
            rep.status = ST_FULL;
        end else if (r.kind == REQ_POS && n != 0 && r.pos > n) begin
            rep.status = ST_BOUND;
        end else begin
            case (r.kind)
                REQ_HEAD: list_image.push_front(r.value);
                REQ_TAIL: list_image.push_back(r.value);
                default:  list_image.insert((n == 0) ? 0 : int'(r.pos), r.value);
            endcase
            sum_image = sum_image + {{(SUM_W-VAL_W){r.value[VAL_W-1]}}, r.value};
        end
        rep.count = CNT_W'(list_image.size());
        rep.total = sum_image;
        return rep;
    endfunction

    // Requests mostly follow a fill or drain run so that the list keeps
    // travelling between empty and full, with some noise mixed in.
    function automatic t_list_row random_request();
        t_list_row r;
        int        n;
        int        roll;
        bit        ins;
        r = '0;
        n = list_image.size();
        if (growing && n == CAPACITY && $urandom_range(0, 3) == 0) begin
            growing = 1'b0;
        end else if (!growing && n == 0 && $urandom_range(0, 3) == 0) begin
            growing = 1'b1;
            fill_style = t_fill_style'($urandom_range(FILL_RANDOM, FILL_EDGE));
        end else if ($urandom_range(0, 299) == 0) begin
            growing = !growing;
        end
        case (fill_style)
            FILL_MIN: r.value = 32'h8000_0000;
            FILL_MAX: r.value = 32'h7FFF_FFFF;
            FILL_EDGE: r.value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                      : 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: r.value = $urandom();
        endcase
        roll = $urandom_range(0, 99);
        ins = growing ? (roll < 85) : (roll >= 85);
        if (roll < 8) begin
            r.kind = REQ_W'($urandom_range(REQ_HEAD, REQ_DEL));
            r.pos  = POS_W'($urandom_range(0, 127));
        end else if (ins) begin
            r.kind = REQ_W'($urandom_range(REQ_HEAD, REQ_POS));
            r.pos  = POS_W'($urandom_range(0, n));
        end else begin
            r.kind = REQ_DEL;
            r.pos  = (n > 0) ? POS_W'($urandom_range(0, n - 1))
                             : POS_W'($urandom_range(0, 127));
        end
        return r;
    endfunction

    task automatic set_idling(input int idx);
        if (idx < (N_DIRECTED + N_RANDOM) / 3) begin
            tx_idle_pct = 33;
            rx_idle_pct = 49;
        end else if (idx < 2 * (N_DIRECTED + N_RANDOM) / 3) begin
            tx_idle_pct = 49;
            rx_idle_pct = 33;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item
    // was taken, leaving valid high for a back-to-back item.
    task automatic offer(input t_list_row r, input t_list_reply want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.pos, r.value};
        s_tuser  <= r.kind;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_replies.push_back(want);
        items_taken++;
        @(negedge i_clk);
    endtask

    initial begin
        t_list_row   r;
        t_list_reply want;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            set_idling(i);
            r = directed_rows[i];
            want = update_list_image(r);
            if (r.typed) begin
                want = '{r.status, r.count, r.total};
            end
            offer(r, want);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            set_idling(N_DIRECTED + i);
            r = random_request();
            want = update_list_image(r);
            offer(r, want);
        end
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long output stalls while the sender keeps offering, so the block backs up.
    initial begin
        for (int k = 0; k < 2; k++) begin
            while (items_taken < 300 + k * 1200) @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_list_reply got;
        t_list_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.count  = m_tdata[6:0];
            got.total  = m_tdata[44:7];
            if (pending_replies.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result: status %0d count %0d total %0d",
                             got.status, got.count, $signed(got.total));
                end
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.count !== want.count ||
                    got.total !== want.total) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch: expected status %0d count %0d total %0d, ",
                                 want.status, want.count, $signed(want.total),
                                 "got status %0d count %0d total %0d",
                                 got.status, got.count, $signed(got.total));
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
src/plst_pkg.sv
src/plst_cell.sv
src/positional_list_store.sv
bench/testbench.sv
